### src/orf_pkg.sv
package orf_pkg;

    // Fixed sizing of the ring and of its message words.
    localparam int SLOT_COUNT = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(SLOT_COUNT);
    localparam int SLOTS_W    = PTR_W + 1;
    localparam int TOTAL_W    = 32;

    // Slot count after reset and the legal range of the slot count register.
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = SLOTS_W'(SLOT_COUNT);
    localparam logic [SLOTS_W-1:0] SLOTS_MIN   = SLOTS_W'(2);
    localparam logic [SLOTS_W-1:0] SLOTS_MAX   = SLOTS_W'(SLOT_COUNT);

    // Operation codes of an input request.
    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2,
        OP_NOP = 2'd3
    } t_opcode;

    // Access to the message store for one request.
    typedef struct packed {
        logic                  wr_en;
        logic [PTR_W-1:0]      wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [PTR_W-1:0]      rd_addr;
    } t_mem_req;

    // One result as it moves through the output stages.
    typedef struct packed {
        logic [PTR_W-1:0]      slot_index;
        logic [DATA_WIDTH-1:0] read_data;
        logic [PTR_W-1:0]      item_count;
        logic [PTR_W-1:0]      free_count;
        logic                  ring_empty;
        logic                  ring_full;
        logic                  dropped_oldest;
        logic                  dequeue_refused;
        logic [TOTAL_W-1:0]    enqueued_total;
        logic [TOTAL_W-1:0]    dequeued_total;
    } t_result;

endpackage

### src/orf_in_if.sv
interface orf_in_if;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [orf_pkg::DATA_WIDTH-1:0] write_data;
    logic                           store_data;

    modport source (output valid, output opcode, output write_data, output store_data,
                    input ready);
    modport sink   (input valid, input opcode, input write_data, input store_data,
                    output ready);

endinterface

### src/orf_out_if.sv
interface orf_out_if;

    logic                           valid;
    logic                           ready;
    logic [orf_pkg::PTR_W-1:0]      slot_index;
    logic [orf_pkg::DATA_WIDTH-1:0] read_data;
    logic [orf_pkg::PTR_W-1:0]      item_count;
    logic [orf_pkg::PTR_W-1:0]      free_count;
    logic                           ring_empty;
    logic                           ring_full;
    logic                           dropped_oldest;
    logic                           dequeue_refused;
    logic [orf_pkg::TOTAL_W-1:0]    enqueued_total;
    logic [orf_pkg::TOTAL_W-1:0]    dequeued_total;

    modport source (output valid, output slot_index, output read_data, output item_count,
                    output free_count, output ring_empty, output ring_full,
                    output dropped_oldest, output dequeue_refused, output enqueued_total,
                    output dequeued_total, input ready);
    modport sink   (input valid, input slot_index, input read_data, input item_count,
                    input free_count, input ring_empty, input ring_full,
                    input dropped_oldest, input dequeue_refused, input enqueued_total,
                    input dequeued_total, output ready);

endinterface

### src/overwriting_ring_fifo.sv
// Overwriting ring FIFO of up to 16 slots of 32-bit words, one slot always kept
// empty, so the ring holds at most slots_in_use - 1 items. Each request (enqueue,
// dequeue, clear or no operation) yields exactly one result with the slot used, the
// dequeued word, the fill status and the enqueue and dequeue totals. An enqueue into
// a full ring drops the oldest item; a dequeue from an empty ring is refused. One
// request is taken per clock cycle unless the output stalls. When it is taken, the
// pointers are updated and the message store, whose read port is registered, is
// read into the pending stage; the result then moves on to the output register.
// Writing the slot count register (clamped to 2..16) empties the ring; write it
// only while no request is in flight.
module overwriting_ring_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [orf_pkg::SLOTS_W-1:0] i_cfg_wdata,
    orf_in_if.sink                      i_req,
    orf_out_if.source                   o_res
);

    localparam int PW = orf_pkg::PTR_W;
    localparam int SW = orf_pkg::SLOTS_W;

    logic [SW-1:0]                  r_slots;
    logic [PW-1:0]                  r_wp;
    logic [PW-1:0]                  r_rp;
    logic [orf_pkg::TOTAL_W-1:0]    r_enq;
    logic [orf_pkg::TOTAL_W-1:0]    r_deq;
    logic                           r_p_valid;
    logic                           r_p_rd;
    orf_pkg::t_result               r_p_res;
    logic                           r_o_valid;
    orf_pkg::t_result               r_o_res;

    logic [SW-1:0]                  n_slots;
    logic [PW-1:0]                  n_wp;
    logic [PW-1:0]                  n_rp;
    logic [orf_pkg::TOTAL_W-1:0]    n_enq;
    logic [orf_pkg::TOTAL_W-1:0]    n_deq;
    logic                           n_rd;
    orf_pkg::t_result               n_res;
    orf_pkg::t_result               n_o_res;
    orf_pkg::t_mem_req              mem_req;
    logic [orf_pkg::DATA_WIDTH-1:0] mem_rd_data;
    logic [SW-1:0]                  count_w;
    logic                           accept;
    logic                           p_move;

    // Increment a pointer and wrap at the slot count.
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SW-1:0] s);
        logic [SW-1:0] n;
        n = {1'b0, p} + SW'(1);
        return (n >= s) ? '0 : n[PW-1:0];
    endfunction

    // Handshake: the pending stage moves on when the output register is free.
    assign p_move      = r_p_valid && (!r_o_valid || o_res.ready);
    assign i_req.ready = !r_p_valid || p_move;
    assign accept      = i_req.valid && i_req.ready;

    // Clamp the requested slot count into the legal range.
    always_comb begin
        if (i_cfg_wdata < orf_pkg::SLOTS_MIN) begin
            n_slots = orf_pkg::SLOTS_MIN;
        end else if (i_cfg_wdata > orf_pkg::SLOTS_MAX) begin
            n_slots = orf_pkg::SLOTS_MAX;
        end else begin
            n_slots = i_cfg_wdata;
        end
    end

    // Decode the request and work out the next pointers, totals and status.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_enq   = r_enq;
        n_deq   = r_deq;
        n_rd    = 1'b0;
        n_res   = '0;
        mem_req = '0;
        mem_req.wr_addr = r_wp;
        mem_req.wr_data = i_req.write_data;
        mem_req.rd_addr = r_rp;

        unique case (orf_pkg::t_opcode'(i_req.opcode))
            orf_pkg::OP_ENQ: begin
                n_res.slot_index = r_wp;
                mem_req.wr_en    = accept && i_req.store_data;
                n_enq            = r_enq + orf_pkg::TOTAL_W'(1);
                n_wp             = adv(r_wp, r_slots);
                if (n_wp == r_rp) begin
                    n_rp                 = adv(r_rp, r_slots);
                    n_res.dropped_oldest = 1'b1;
                end
            end
            orf_pkg::OP_DEQ: begin
                n_res.slot_index = r_rp;
                if (r_wp == r_rp) begin
                    n_res.dequeue_refused = 1'b1;
                end else begin
                    n_rd          = 1'b1;
                    mem_req.rd_en = accept;
                    n_rp          = adv(r_rp, r_slots);
                    n_deq         = r_deq + orf_pkg::TOTAL_W'(1);
                end
            end
            orf_pkg::OP_CLR: begin
                n_wp  = '0;
                n_rp  = '0;
                n_deq = r_enq;
            end
            orf_pkg::OP_NOP: begin
                n_res.slot_index = '0;
            end
            default: begin
                n_res.slot_index = '0;
            end
        endcase

        // Fill level after the step.
        if (n_wp >= n_rp) begin
            count_w = {1'b0, n_wp} - {1'b0, n_rp};
        end else begin
            count_w = {1'b0, n_wp} + r_slots - {1'b0, n_rp};
        end
        n_res.item_count     = count_w[PW-1:0];
        n_res.free_count     = PW'(r_slots - SW'(1) - count_w);
        n_res.ring_empty     = (n_wp == n_rp);
        n_res.ring_full      = (count_w == r_slots - SW'(1));
        n_res.enqueued_total = n_enq;
        n_res.dequeued_total = n_deq;
    end

    orf_store u_store (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // Ring state: slot count, pointers and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= orf_pkg::SLOTS_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_enq   <= '0;
            r_deq   <= '0;
        end else if (i_cfg_we) begin
            r_slots <= n_slots;
            r_wp    <= '0;
            r_rp    <= '0;
        end else if (accept) begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_enq   <= n_enq;
            r_deq   <= n_deq;
        end
    end

    // Pending stage: waits for the store's read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_res <= n_res;
            r_p_rd  <= n_rd;
        end
    end

    // Merge the read data into the pending result.
    always_comb begin
        n_o_res           = r_p_res;
        n_o_res.read_data = r_p_rd ? mem_rd_data : '0;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.slot_index      = r_o_res.slot_index;
    assign o_res.read_data       = r_o_res.read_data;
    assign o_res.item_count      = r_o_res.item_count;
    assign o_res.free_count      = r_o_res.free_count;
    assign o_res.ring_empty      = r_o_res.ring_empty;
    assign o_res.ring_full       = r_o_res.ring_full;
    assign o_res.dropped_oldest  = r_o_res.dropped_oldest;
    assign o_res.dequeue_refused = r_o_res.dequeue_refused;
    assign o_res.enqueued_total  = r_o_res.enqueued_total;
    assign o_res.dequeued_total  = r_o_res.dequeued_total;

endmodule

### src/orf_store.sv
module orf_store (
    input  logic                           i_clk,
    input  orf_pkg::t_mem_req              i_mem,
    output logic [orf_pkg::DATA_WIDTH-1:0] o_rd_data
);

    logic [orf_pkg::DATA_WIDTH-1:0] r_mem [orf_pkg::SLOT_COUNT];
    logic [orf_pkg::DATA_WIDTH-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rd_data <= r_mem[i_mem.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/orf_checker.sv
module orf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [orf_pkg::PTR_W-1:0]      i_slot_index,
    input logic [orf_pkg::DATA_WIDTH-1:0] i_read_data,
    input logic [orf_pkg::PTR_W-1:0]      i_item_count,
    input logic [orf_pkg::PTR_W-1:0]      i_free_count,
    input logic                           i_ring_empty,
    input logic                           i_ring_full,
    input logic                           i_dropped_oldest,
    input logic                           i_dequeue_refused
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_slot_index) && $stable(i_read_data)
            && $stable(i_item_count))
        else $error("result changed while stalled");

    // The empty flag agrees with the item count.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_ring_empty == (i_item_count == '0)))
        else $error("empty flag disagrees with item count");

    // A full ring has no free space.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ring_full |-> (i_free_count == '0))
        else $error("full ring reports free space");

    // Dropping the oldest item leaves the ring full.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dropped_oldest |-> i_ring_full && !i_dequeue_refused)
        else $error("overwrite did not leave ring full");

    // A refused dequeue comes from an empty ring and returns no data.
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dequeue_refused |-> i_ring_empty && (i_read_data == '0))
        else $error("refused dequeue with data or non-empty ring");

endmodule

bind overwriting_ring_fifo orf_checker u_orf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_res.valid),
    .i_ready           (o_res.ready),
    .i_slot_index      (o_res.slot_index),
    .i_read_data       (o_res.read_data),
    .i_item_count      (o_res.item_count),
    .i_free_count      (o_res.free_count),
    .i_ring_empty      (o_res.ring_empty),
    .i_ring_full       (o_res.ring_full),
    .i_dropped_oldest  (o_res.dropped_oldest),
    .i_dequeue_refused (o_res.dequeue_refused)
);
